@@ design/hsv_brightness_reduce_assert.svh @@
// Assertion macros used by the checker file of the HSV brightness block.
`ifndef HSV_BRIGHTNESS_REDUCE_ASSERT_SVH
`define HSV_BRIGHTNESS_REDUCE_ASSERT_SVH

// Implication checked at every rising clock edge outside reset.
`define HBR_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hbr assertion failed");

// Expression that holds at every rising clock edge outside reset.
`define HBR_ASSERT_ALWAYS(lbl, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("hbr assertion failed");

`endif

@@ design/hbr_pkg.sv @@
// Shared types and codes of the HSV brightness reduction block.
package hbr_pkg;

    localparam int NUM_LANES = 2;
    localparam int BYTE_W    = 8;

    localparam logic [1:0] SEL_R = 2'd0;
    localparam logic [1:0] SEL_G = 2'd1;
    localparam logic [1:0] SEL_B = 2'd2;

    typedef struct packed {
        logic       black;
        logic       grey;
        logic       neg;
        logic [1:0] sel;
        logic [7:0] mx;
    } hbr_side_t;

endpackage

@@ design/hbr_div.sv @@
// Pipelined restoring divider over parallel lanes, one quotient bit per stage.
module hbr_div #(
    parameter int FRAC_BITS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic [7:0]            dvd [hbr_pkg::NUM_LANES],
    input  logic [7:0]            dsr [hbr_pkg::NUM_LANES],
    input  hbr_pkg::hbr_side_t    in_side,
    output logic                  out_valid,
    output logic [FRAC_BITS:0]    quo [hbr_pkg::NUM_LANES],
    output hbr_pkg::hbr_side_t    out_side
);
    import hbr_pkg::*;

    localparam int W = FRAC_BITS + BYTE_W;

    logic              valid_reg [W+1];
    hbr_side_t         side_reg  [W+1];
    logic [W-1:0]      dq_reg    [W+1][NUM_LANES];
    logic [7:0]        rem_reg   [W+1][NUM_LANES];
    logic [7:0]        dsr_reg   [W+1][NUM_LANES];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg[0] <= 1'b0;
        end
        else
        begin
            valid_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        side_reg[0] <= in_side;
        for (int l = 0; l < NUM_LANES; l++)
        begin
            dq_reg[0][l]  <= {dvd[l], {FRAC_BITS{1'b0}}};
            rem_reg[0][l] <= '0;
            dsr_reg[0][l] <= dsr[l];
        end
    end

    for (genvar i = 0; i < W; i++)
    begin : g_stage
        logic [W-1:0] dq_next  [NUM_LANES];
        logic [7:0]   rem_next [NUM_LANES];

        always_comb
        begin
            logic [8:0] tmp;
            logic       ge;
            for (int l = 0; l < NUM_LANES; l++)
            begin
                tmp         = {rem_reg[i][l], dq_reg[i][l][W-1]};
                ge          = (tmp >= {1'b0, dsr_reg[i][l]});
                rem_next[l] = ge ? 8'(tmp - {1'b0, dsr_reg[i][l]}) : tmp[7:0];
                dq_next[l]  = {dq_reg[i][l][W-2:0], ge};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[i+1] <= 1'b0;
            end
            else
            begin
                valid_reg[i+1] <= valid_reg[i];
            end
        end

        always_ff @(posedge clk)
        begin
            side_reg[i+1] <= side_reg[i];
            for (int l = 0; l < NUM_LANES; l++)
            begin
                dq_reg[i+1][l]  <= dq_next[l];
                rem_reg[i+1][l] <= rem_next[l];
                dsr_reg[i+1][l] <= dsr_reg[i][l];
            end
        end
    end

    assign out_valid = valid_reg[W];
    assign out_side  = side_reg[W];

    always_comb
    begin
        for (int l = 0; l < NUM_LANES; l++)
        begin
            quo[l] = dq_reg[W][l][FRAC_BITS:0];
        end
    end

endmodule

@@ design/hsv_brightness_reduce.sv @@
// Top level of the HSV brightness reduction pipeline.
//
//  channel   signals                     transfer
//  input     start, busy, rgb_in         start high and busy low at a clock edge
//  config    cfg_valid, cfg_ready, data  cfg_valid and cfg_ready high at a clock edge
//  result    done, rgb_out               done high for one cycle, always taken
//
// One colour enters per cycle; busy stays low. The divider produces one quotient bit
// per stage over FRAC_BITS + 8 stages, and five more stages hold the compare, hue,
// products, and channel selection. Reset clears the valid bits and the level.
// Nothing stalls, since the receiver always takes the result.
module hsv_brightness_reduce #(
    parameter int FRAC_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [23:0] rgb_in,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_data,
    output logic        done,
    output logic [23:0] rgb_out
);
    import hbr_pkg::*;

    localparam int QW = FRAC_BITS + 1;
    localparam int HW = FRAC_BITS + 4;
    localparam int VM = FRAC_BITS % 8;
    localparam logic [QW-1:0] ONE_Q   = QW'(1 << FRAC_BITS);
    localparam logic [QW-1:0] FLOOR_Q = QW'((1 << FRAC_BITS) / 100);
    localparam logic [QW-1:0] V_K     = QW'(((1 << FRAC_BITS) - (1 << VM)) / 255);
    localparam logic [HW-1:0] SIX_Q   = HW'(6 << FRAC_BITS);
    localparam logic [QW-1:0] OFF_TAB [5] = '{
        QW'((9 << FRAC_BITS) / 10), QW'((7 << FRAC_BITS) / 10),
        QW'((5 << FRAC_BITS) / 10), QW'((3 << FRAC_BITS) / 10),
        QW'((1 << FRAC_BITS) / 10)};

    logic [2:0] level_reg;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            level_reg <= cfg_data;
        end
    end

    logic [7:0] r, g, b, mx, mn, dd, dm;
    logic [7:0] dvd [NUM_LANES];
    logic [7:0] dsr [NUM_LANES];
    hbr_side_t  in_side;

    always_comb
    begin
        logic [7:0] a;
        logic [7:0] c;
        r  = rgb_in[23:16];
        g  = rgb_in[15:8];
        b  = rgb_in[7:0];
        mx = r;
        if (g > mx) mx = g;
        if (b > mx) mx = b;
        mn = r;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        dd = mx - mn;
        priority if (mx == r)
        begin
            in_side.sel = SEL_R;
            a = g;
            c = b;
        end
        else if (mx == g)
        begin
            in_side.sel = SEL_G;
            a = b;
            c = r;
        end
        else
        begin
            in_side.sel = SEL_B;
            a = r;
            c = g;
        end
        in_side.neg   = (a < c);
        dm            = in_side.neg ? c - a : a - c;
        in_side.black = (rgb_in == 24'd0);
        in_side.grey  = (dd == 8'd0);
        in_side.mx    = mx;
        dvd[0] = dd;
        dsr[0] = mx;
        dvd[1] = dm;
        dsr[1] = dd;
    end

    logic          dv_valid;
    logic [QW-1:0] quo [NUM_LANES];
    hbr_side_t     dv_side;

    hbr_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start && !busy),
        .dvd       (dvd),
        .dsr       (dsr),
        .in_side   (in_side),
        .out_valid (dv_valid),
        .quo       (quo),
        .out_side  (dv_side)
    );

    // Hue, sector and adjusted value.
    logic                 c_valid_reg;
    logic                 c_black_reg;
    logic [QW-1:0]        c_v_reg, c_s_reg;
    logic [2:0]           c_sec_reg;
    logic [FRAC_BITS-1:0] c_f_reg;
    logic [HW-1:0]        h6;
    logic [QW-1:0]        v_next;

    // V is max * ONE / 255, split into an exact multiple and a small remainder term.
    always_comb
    begin
        logic [HW-1:0] base;
        logic [2:0]    lvl;
        logic [15:0]   vy;
        logic [15:0]   vc;
        logic [QW-1:0] vq;
        unique case (dv_side.sel)
            SEL_R:   base = '0;
            SEL_G:   base = HW'(2 << FRAC_BITS);
            default: base = HW'(4 << FRAC_BITS);
        endcase
        if (dv_side.grey)
        begin
            h6 = '0;
        end
        else
        begin
            h6 = dv_side.neg ? base + SIX_Q - HW'(quo[1]) : base + HW'(quo[1]);
            if (h6 >= SIX_Q) h6 = h6 - SIX_Q;
        end
        vy     = 16'({8'd0, dv_side.mx} << VM);
        vc     = 16'(vy + 16'd1 + (vy >> 8)) >> 8;
        vq     = QW'(dv_side.mx) * V_K + QW'(vc);
        lvl    = (level_reg > 3'd4) ? 3'd4 : level_reg;
        v_next = (vq >= OFF_TAB[lvl]) ? vq - OFF_TAB[lvl] : FLOOR_Q;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_valid_reg <= 1'b0;
        end
        else
        begin
            c_valid_reg <= dv_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        c_black_reg <= dv_side.black;
        c_v_reg     <= v_next;
        c_s_reg     <= quo[0];
        c_sec_reg   <= h6[FRAC_BITS+2:FRAC_BITS];
        c_f_reg     <= h6[FRAC_BITS-1:0];
    end

    // First products.
    logic          d_valid_reg, d_black_reg;
    logic [QW-1:0] d_v_reg, d_p_reg, d_fs_reg, d_gs_reg;
    logic [2:0]    d_sec_reg;
    logic [2*QW-1:0] prod_p, prod_fs, prod_gs;

    assign prod_p  = (2*QW)'(c_v_reg) * (2*QW)'(ONE_Q - c_s_reg);
    assign prod_fs = (2*QW)'(c_f_reg) * (2*QW)'(c_s_reg);
    assign prod_gs = (2*QW)'(ONE_Q - QW'(c_f_reg)) * (2*QW)'(c_s_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_valid_reg <= 1'b0;
        end
        else
        begin
            d_valid_reg <= c_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        d_black_reg <= c_black_reg;
        d_v_reg     <= c_v_reg;
        d_sec_reg   <= c_sec_reg;
        d_p_reg     <= prod_p[FRAC_BITS +: QW];
        d_fs_reg    <= prod_fs[FRAC_BITS +: QW];
        d_gs_reg    <= prod_gs[FRAC_BITS +: QW];
    end

    // Second products.
    logic            e_valid_reg, e_black_reg;
    logic [QW-1:0]   e_v_reg, e_p_reg, e_q_reg, e_t_reg;
    logic [2:0]      e_sec_reg;
    logic [2*QW-1:0] prod_q, prod_t;

    assign prod_q = (2*QW)'(d_v_reg) * (2*QW)'(ONE_Q - d_fs_reg);
    assign prod_t = (2*QW)'(d_v_reg) * (2*QW)'(ONE_Q - d_gs_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_valid_reg <= 1'b0;
        end
        else
        begin
            e_valid_reg <= d_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        e_black_reg <= d_black_reg;
        e_v_reg     <= d_v_reg;
        e_p_reg     <= d_p_reg;
        e_sec_reg   <= d_sec_reg;
        e_q_reg     <= prod_q[FRAC_BITS +: QW];
        e_t_reg     <= prod_t[FRAC_BITS +: QW];
    end

    // Channel selection and scaling to bytes.
    logic        done_reg;
    logic [23:0] rgb_reg;
    logic [23:0] rgb_next;

    function automatic logic [7:0] to_byte(input logic [QW-1:0] x);
        logic [QW+7:0] m;
        m = {x, 8'd0} - (QW+8)'(x);
        return m[FRAC_BITS +: 8];
    endfunction

    always_comb
    begin
        logic [QW-1:0] ro, go, bo;
        unique case (e_sec_reg)
            3'd0:    begin ro = e_v_reg; go = e_t_reg; bo = e_p_reg; end
            3'd1:    begin ro = e_q_reg; go = e_v_reg; bo = e_p_reg; end
            3'd2:    begin ro = e_p_reg; go = e_v_reg; bo = e_t_reg; end
            3'd3:    begin ro = e_p_reg; go = e_q_reg; bo = e_v_reg; end
            3'd4:    begin ro = e_t_reg; go = e_p_reg; bo = e_v_reg; end
            default: begin ro = e_v_reg; go = e_p_reg; bo = e_q_reg; end
        endcase
        rgb_next = e_black_reg ? 24'd0 : {to_byte(ro), to_byte(go), to_byte(bo)};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= e_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        rgb_reg <= rgb_next;
    end

    assign done    = done_reg;
    assign rgb_out = rgb_reg;

endmodule

@@ design/hsv_brightness_reduce_chk.sv @@
// Port-level checker for the HSV brightness reduction block and its bind.
`include "hsv_brightness_reduce_assert.svh"

module hsv_brightness_reduce_chk #(
    parameter int FRAC_BITS = 16
) (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic [23:0] rgb_in,
    input logic        cfg_valid,
    input logic        cfg_ready,
    input logic        done,
    input logic [23:0] rgb_out
);
    localparam int LAT = FRAC_BITS + 13;
    localparam int CW  = $clog2(LAT + 1);

    logic [CW-1:0] warm_reg;
    logic          warm;
    logic          in_xfer;
    logic          in_black;
    logic          in_grey;
    logic          out_grey;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            warm_reg <= '0;
        end
        else if (warm_reg != CW'(LAT))
        begin
            warm_reg <= warm_reg + 1'b1;
        end
    end

    assign warm     = (warm_reg == CW'(LAT));
    assign in_xfer  = start && !busy;
    assign in_black = in_xfer && (rgb_in == 24'd0);
    assign in_grey  = in_xfer && (rgb_in[23:16] == rgb_in[15:8])
                      && (rgb_in[15:8] == rgb_in[7:0]);
    assign out_grey = (rgb_out[23:16] == rgb_out[15:8]) && (rgb_out[15:8] == rgb_out[7:0]);

    `HBR_ASSERT_ALWAYS(a_never_busy, !busy && (cfg_ready || !cfg_valid))
    `HBR_ASSERT_IMPL(a_latency, warm, done == $past(in_xfer, LAT))
    `HBR_ASSERT_IMPL(a_black, warm && $past(in_black, LAT), rgb_out == 24'd0)
    `HBR_ASSERT_IMPL(a_grey, warm && $past(in_grey, LAT), out_grey)

endmodule

bind hsv_brightness_reduce hsv_brightness_reduce_chk #(.FRAC_BITS(FRAC_BITS)) u_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .rgb_in    (rgb_in),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .done      (done),
    .rgb_out   (rgb_out)
);

@@ tb/testbench.sv @@
// Self-checking testbench for the HSV brightness reduction block.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC_BITS = 16;
    localparam int LATENCY = FRAC_BITS + 13;
    localparam longint ONE_Q = 64'd1 << FRAC_BITS;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic [23:0] rgb_in = '0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [2:0] cfg_data = '0;
    logic done;
    logic [23:0] rgb_out;

    logic [2:0] level_shadow = '0;
    logic [23:0] dimmed_queue[$];
    int fail_count = 0;

    hsv_brightness_reduce #(.FRAC_BITS(FRAC_BITS)) dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .rgb_in(rgb_in),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .done(done), .rgb_out(rgb_out)
    );

    always #4 clk = ~clk;

    function automatic logic [7:0] channel_byte(longint unsigned x);
        channel_byte = 8'((x * 255) >> FRAC_BITS);
    endfunction

    function automatic logic [23:0] dim_color(logic [23:0] c, logic [2:0] lvl);
        longint unsigned r, g, b, mx, mn, d, v, s, h6, base, mag, off, f, p, q, t;
        longint unsigned ro, go, bo, a, bb;
        int sector;
        logic [2:0] l;
        if (c == 0)
            return 24'd0;
        r = c[23:16];
        g = c[15:8];
        b = c[7:0];
        mx = r;
        if (g > mx) mx = g;
        if (b > mx) mx = b;
        mn = r;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        d = mx - mn;
        v = (mx << FRAC_BITS) / 255;
        s = (d << FRAC_BITS) / mx;
        h6 = 0;
        if (d != 0)
        begin
            if (mx == r)
            begin
                a = g; bb = b; base = 0;
            end
            else if (mx == g)
            begin
                a = b; bb = r; base = 2 * ONE_Q;
            end
            else
            begin
                a = r; bb = g; base = 4 * ONE_Q;
            end
            if (a >= bb)
                h6 = base + (((a - bb) << FRAC_BITS) / d);
            else
                h6 = base + 6 * ONE_Q - (((bb - a) << FRAC_BITS) / d);
            if (h6 >= 6 * ONE_Q)
                h6 -= 6 * ONE_Q;
        end
        l = (lvl > 3'd4) ? 3'd4 : lvl;
        case (l)
            3'd0: off = (64'd9 << FRAC_BITS) / 10;
            3'd1: off = (64'd7 << FRAC_BITS) / 10;
            3'd2: off = (64'd5 << FRAC_BITS) / 10;
            3'd3: off = (64'd3 << FRAC_BITS) / 10;
            default: off = (64'd1 << FRAC_BITS) / 10;
        endcase
        if (v >= off)
            v -= off;
        else
            v = ONE_Q / 100;
        sector = int'((h6 >> FRAC_BITS) % 6);
        f = h6 & (ONE_Q - 1);
        p = (v * (ONE_Q - s)) >> FRAC_BITS;
        q = (v * (ONE_Q - ((f * s) >> FRAC_BITS))) >> FRAC_BITS;
        t = (v * (ONE_Q - (((ONE_Q - f) * s) >> FRAC_BITS))) >> FRAC_BITS;
        case (sector)
            0: begin ro = v; go = t; bo = p; end
            1: begin ro = q; go = v; bo = p; end
            2: begin ro = p; go = v; bo = t; end
            3: begin ro = p; go = q; bo = v; end
            4: begin ro = t; go = p; bo = v; end
            default: begin ro = v; go = p; bo = q; end
        endcase
        return {channel_byte(ro), channel_byte(go), channel_byte(bo)};
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (dimmed_queue.size() == 0)
            begin
                $error("rgb_out: unexpected result %06h", rgb_out);
                fail_count++;
            end
            else
            begin
                logic [23:0] want;
                want = dimmed_queue.pop_front();
                if (rgb_out !== want)
                begin
                    $error("rgb_out: expected %06h actual %06h", want, rgb_out);
                    fail_count++;
                end
            end
        end
    end

    task automatic send_color(logic [23:0] c, bit may_idle, logic [23:0] typed, bit has_typed);
        while (may_idle && $urandom_range(99) < 26)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        rgb_in <= c;
        do
            @(posedge clk);
        while (busy);
        dimmed_queue.push_back(has_typed ? typed : dim_color(c, level_shadow));
    endtask

    task automatic settle;
        start <= 1'b0;
        while (dimmed_queue.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    task automatic write_level(logic [2:0] lvl);
        cfg_valid <= 1'b1;
        cfg_data <= lvl;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        level_shadow = lvl;
        @(posedge clk);
    endtask

    typedef struct {
        logic [23:0] color;
        bit has_typed;
        logic [23:0] typed;
    } color_row_t;

    color_row_t directed_rows[] = '{
        '{24'h000000, 1'b1, 24'h000000},
        '{24'hFFFFFF, 1'b0, 24'h0},
        '{24'h010101, 1'b0, 24'h0},
        '{24'h808080, 1'b0, 24'h0},
        '{24'hFF0000, 1'b0, 24'h0},
        '{24'h00FF00, 1'b0, 24'h0},
        '{24'h0000FF, 1'b0, 24'h0},
        '{24'hFFFF00, 1'b0, 24'h0},
        '{24'h00FFFF, 1'b0, 24'h0},
        '{24'hFF00FF, 1'b0, 24'h0},
        '{24'hFF0080, 1'b0, 24'h0},
        '{24'h80FF10, 1'b0, 24'h0},
        '{24'h1080FF, 1'b0, 24'h0},
        '{24'hE6E6E6, 1'b0, 24'h0},
        '{24'h55AA33, 1'b0, 24'h0},
        '{24'h0F0E01, 1'b0, 24'h0}
    };

    initial
    begin
        logic [2:0] levels[6] = '{3'd0, 3'd4, 3'd2, 3'd7, 3'd1, 3'd3};
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (directed_rows[i])
            send_color(directed_rows[i].color, 1'b0, directed_rows[i].typed,
                       directed_rows[i].has_typed);
        foreach (levels[k])
        begin
            settle();
            write_level(levels[k]);
            foreach (directed_rows[i])
                send_color(directed_rows[i].color, 1'b1, 24'h0, 1'b0);
            for (int n = 0; n < 60; n++)
            begin
                logic [23:0] c;
                c = 24'($urandom);
                if ($urandom_range(9) == 0)
                    c = {3{8'($urandom)}};
                send_color(c, k != 2, 24'h0, 1'b0);
            end
        end
        settle();
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        #2ms;
        $display("Regression FAIL");
        $finish;
    end
endmodule

@@ sim.f @@
+incdir+design
design/hbr_pkg.sv
design/hbr_div.sv
design/hsv_brightness_reduce.sv
design/hsv_brightness_reduce_chk.sv
tb/testbench.sv
